// ===== hdl/rlce_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB LED chain pulse encoder package
// Shared constants, item codes and the slot descriptor type.
// ----------------------------------------------------------------------------
`default_nettype none

package rlce_pkg;

  localparam int LED_COUNT_DEF = 8;

  localparam int BITS_PER_LED = 24;
  localparam int BIT_POS_W    = 5;
  localparam int DUTY_W       = 16;
  localparam int GAP_W        = 8;
  localparam int COLOUR_W     = 24;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [1:0] MODE_SET  = 2'd0;
  localparam logic [1:0] MODE_SHOW = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_DUTY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_DUTY  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAP_SLOTS = 2'd2;

  localparam logic [DUTY_W-1:0] ZERO_DUTY_RESET = 16'd29;
  localparam logic [DUTY_W-1:0] ONE_DUTY_RESET  = 16'd67;
  localparam logic [GAP_W-1:0]  GAP_SLOTS_RESET = 8'd50;

  typedef struct packed {
    logic                 sending;
    logic                 data;
    logic [BIT_POS_W-1:0] shift;
    logic                 last;
  } slot_t;

endpackage

`default_nettype wire

// ===== hdl/rgb_led_chain_pulse_encoder.sv =====
// ----------------------------------------------------------------------------
// RGB LED chain pulse encoder
// Colour store and per-slot PWM compare value generator for an LED chain.
// ----------------------------------------------------------------------------
// Each input transaction is a set (write one LED colour), a show (start a
// frame if none is running) or a tick (one bit slot). Every tick returns
// exactly one output transaction: the one-duty or zero-duty for the current
// data bit, sent green, red, blue and most significant bit first, zeros in
// the reset gap and while idle, with tlast on the final slot of a frame. The
// block takes one input transaction per cycle unless the output stalls; a
// tick's result passes the registered colour RAM read and then the output
// register. Colours live in a RAM holding two copies per LED, so a set during
// a frame never disturbs the colours the frame captured at its start. Duty
// and gap registers take effect at the next show.
`default_nettype none

module rgb_led_chain_pulse_encoder #(
  parameter int LED_COUNT = rlce_pkg::LED_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // tdata: led_id[7:0], red_level[15:8], green_level[23:16], blue_level[31:24]
  input  wire logic [31:0]                     s_tdata,
  // tuser: mode[1:0]
  input  wire logic [1:0]                      s_tuser,
  input  wire logic                            s_tvalid,
  output      logic                            s_tready,
  // tdata: duty_value[15:0]
  output      logic [15:0]                     m_tdata,
  output      logic                            m_tlast,
  output      logic                            m_tvalid,
  input  wire logic                            m_tready,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [rlce_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [15:0]                     cfg_data
);
  import rlce_pkg::*;

  localparam int IW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int AW = IW + 1;

  logic [DUTY_W-1:0] zero_duty;
  logic [DUTY_W-1:0] one_duty;
  logic [GAP_W-1:0]  gap_slots;
  logic [DUTY_W-1:0] frame_zero;
  logic [DUTY_W-1:0] frame_one;

  logic [LED_COUNT-1:0] cur_copy;
  logic [LED_COUNT-1:0] stored;
  logic [LED_COUNT-1:0] frame_copy;
  logic [LED_COUNT-1:0] frame_stored;

  logic [1:0]    mode;
  logic [7:0]    led_id;
  logic [IW-1:0] id_idx;
  logic          id_ok;
  logic          in_acc;
  logic          set_acc;
  logic          show_acc;
  logic          tick_acc;
  logic          wr_copy;

  slot_t         slot;
  logic [IW-1:0] led;

  logic [COLOUR_W-1:0] rd_colour;

  logic                 p_valid;
  logic                 p_data;
  logic                 p_blank;
  logic [BIT_POS_W-1:0] p_shift;
  logic                 p_last;
  logic                 p_adv;

  assign cfg_ready = 1'b1;

  assign mode     = s_tuser;
  assign led_id   = s_tdata[7:0];
  assign id_idx   = led_id[IW-1:0];
  assign id_ok    = ({1'b0, led_id} < 9'(LED_COUNT));
  assign p_adv    = !m_tvalid || m_tready;
  assign s_tready = !p_valid || p_adv;
  assign in_acc   = s_tvalid && s_tready;
  assign set_acc  = in_acc && (mode == MODE_SET) && id_ok;
  assign show_acc = in_acc && (mode == MODE_SHOW) && !slot.sending;
  assign tick_acc = in_acc && (mode == MODE_TICK);
  assign wr_copy  = (slot.sending && (cur_copy[id_idx] == frame_copy[id_idx])) ?
                    !cur_copy[id_idx] : cur_copy[id_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_duty <= ZERO_DUTY_RESET;
      one_duty  <= ONE_DUTY_RESET;
      gap_slots <= GAP_SLOTS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ZERO_DUTY: zero_duty <= cfg_data;
        REG_ONE_DUTY:  one_duty  <= cfg_data;
        REG_GAP_SLOTS: gap_slots <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_copy     <= '0;
      stored       <= '0;
      frame_copy   <= '0;
      frame_stored <= '0;
    end else begin
      if (set_acc) begin
        cur_copy[id_idx] <= wr_copy;
        stored[id_idx]   <= 1'b1;
      end
      if (show_acc) begin
        frame_copy   <= cur_copy;
        frame_stored <= stored;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (show_acc) begin
      frame_zero <= zero_duty;
      frame_one  <= one_duty;
    end
  end

  rlce_slot_ctr #(
    .LED_COUNT (LED_COUNT),
    .IW        (IW)
  ) u_slot_ctr (
    .clk       (clk),
    .rst       (rst),
    .start     (show_acc),
    .tick      (tick_acc),
    .gap_slots (gap_slots),
    .slot      (slot),
    .led       (led)
  );

  rlce_ram #(
    .WIDTH (COLOUR_W),
    .DEPTH (2 ** AW)
  ) u_colour_ram (
    .clk   (clk),
    .we    (set_acc),
    .waddr ({wr_copy, id_idx}),
    .wdata ({s_tdata[23:16], s_tdata[15:8], s_tdata[31:24]}),
    .re    (tick_acc && slot.data),
    .raddr ({frame_copy[led], led}),
    .rdata (rd_colour)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (s_tready) begin
      p_valid <= tick_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      p_data  <= slot.data;
      p_blank <= !frame_stored[led];
      p_shift <= slot.shift;
      p_last  <= slot.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (p_adv) begin
      m_tvalid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_adv && p_valid) begin
      if (!p_data) begin
        m_tdata <= '0;
      end else if (!p_blank && rd_colour[p_shift]) begin
        m_tdata <= frame_one;
      end else begin
        m_tdata <= frame_zero;
      end
      m_tlast <= p_last;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rlce_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rlce_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rlce_slot_ctr.sv =====
// ----------------------------------------------------------------------------
// Frame slot counter
// Tracks LED, bit and reset-gap positions of the running frame.
// ----------------------------------------------------------------------------
`default_nettype none

module rlce_slot_ctr #(
  parameter int LED_COUNT = rlce_pkg::LED_COUNT_DEF,
  parameter int IW        = 3
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic                      tick,
  input  wire logic [rlce_pkg::GAP_W-1:0] gap_slots,
  output      rlce_pkg::slot_t           slot,
  output      logic [IW-1:0]             led
);
  import rlce_pkg::*;

  logic                 sending;
  logic                 in_gap;
  logic [BIT_POS_W-1:0] bit_pos;
  logic [GAP_W-1:0]     gap_pos;
  logic [GAP_W-1:0]     frame_gap;
  logic                 last_data;
  logic [GAP_W:0]       gap_pos_next;

  always_comb begin
    last_data    = (led == IW'(LED_COUNT - 1)) &&
                   (bit_pos == BIT_POS_W'(BITS_PER_LED - 1));
    gap_pos_next = {1'b0, gap_pos} + (GAP_W + 1)'(1);
    slot.sending = sending;
    slot.data    = sending && !in_gap;
    slot.shift   = BIT_POS_W'(BITS_PER_LED - 1) - bit_pos;
    slot.last    = sending && (in_gap ? (gap_pos_next == {1'b0, frame_gap})
                                      : (last_data && (frame_gap == '0)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sending   <= 1'b0;
      in_gap    <= 1'b0;
      led       <= '0;
      bit_pos   <= '0;
      gap_pos   <= '0;
      frame_gap <= '0;
    end else if (start) begin
      sending   <= 1'b1;
      in_gap    <= 1'b0;
      led       <= '0;
      bit_pos   <= '0;
      gap_pos   <= '0;
      frame_gap <= gap_slots;
    end else if (tick && sending) begin
      if (slot.last) begin
        sending <= 1'b0;
        in_gap  <= 1'b0;
        led     <= '0;
        bit_pos <= '0;
        gap_pos <= '0;
      end else if (in_gap) begin
        gap_pos <= gap_pos_next[GAP_W-1:0];
      end else if (bit_pos == BIT_POS_W'(BITS_PER_LED - 1)) begin
        bit_pos <= '0;
        if (last_data) begin
          in_gap <= 1'b1;
        end else begin
          led <= led + IW'(1);
        end
      end else begin
        bit_pos <= bit_pos + BIT_POS_W'(1);
      end
    end
  end

endmodule

`default_nettype wire
